>>> hdl/u16u8_pkg.sv
`default_nettype none

package u16u8_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Top six bits of a code unit that mark the surrogate ranges
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

  localparam logic [7:0] LEAD_2 = 8'hC0;
  localparam logic [7:0] LEAD_3 = 8'hE0;
  localparam logic [7:0] LEAD_4 = 8'hF0;
  localparam logic [7:0] CONT   = 8'h80;

  // One encoded code point: bytes in stream order, index of the final byte
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/utf16_to_utf8_transcoder_top.sv
`default_nettype none

// UTF-16 to UTF-8 transcoder. Each input request carries one UTF-16 code unit
// as two bytes, ordered by the big_endian register, and produces one to four
// UTF-8 bytes on the output, one byte per request, the last flagged with
// out_last_of_run. A high surrogate is held until the next unit; a stray low
// surrogate emits nothing; a broken pair stops output until the end-of-string
// request, which clears the held surrogate and the halt. The front end decodes a
// unit in the cycle it is accepted and writes the encoded bytes into a
// QUEUE_DEPTH-entry queue; the back end drains that queue one byte per cycle,
// while out_stall is low, through a registered output. An input request is
// taken every cycle while the queue has room, so the sustained rate is set by
// the byte-wide output. big_endian is written through the cfg channel, which
// is always ready, and must only change while the block is idle.
module utf16_to_utf8_transcoder_top #(
  parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_big_endian,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_first_byte,
  input  wire logic [7:0] in_second_byte,
  input  wire logic       in_end_of_string,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_utf8_byte,
  output logic            out_last_of_run
);

  logic              big_endian_r;
  logic              accept;
  logic              push;
  logic              pop;
  logic              full;
  logic              head_valid;
  u16u8_pkg::entry_t push_entry;
  u16u8_pkg::entry_t head_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      big_endian_r <= cfg_big_endian;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  u16u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .big_endian    (big_endian_r),
    .accept        (accept),
    .first_byte    (in_first_byte),
    .second_byte   (in_second_byte),
    .end_of_string (in_end_of_string),
    .push          (push),
    .push_entry    (push_entry)
  );

  u16u8_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  u16u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_entry      (head_entry),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_utf8_byte   (out_utf8_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

>>> hdl/u16u8_front.sv
`default_nettype none

module u16u8_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              big_endian,
  input  wire logic              accept,
  input  wire logic [7:0]        first_byte,
  input  wire logic [7:0]        second_byte,
  input  wire logic              end_of_string,
  output logic                   push,
  output u16u8_pkg::entry_t      push_entry
);

  logic [9:0]  held_high_bits_r, held_high_bits_nxt;
  logic        high_waiting_r, high_waiting_nxt;
  logic        halted_r, halted_nxt;

  logic [15:0] unit;
  logic        is_high;
  logic        is_low;
  logic        emit;
  logic        pair;
  logic [20:0] cp;

  assign unit    = big_endian ? {first_byte, second_byte} : {second_byte, first_byte};
  assign is_high = (unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
  assign is_low  = (unit[15:10] == u16u8_pkg::LOW_SURR_TAG);
  assign cp      = u16u8_pkg::SUPP_BASE + {1'b0, held_high_bits_r, unit[9:0]};

  always_comb begin
    held_high_bits_nxt = held_high_bits_r;
    high_waiting_nxt   = high_waiting_r;
    halted_nxt         = halted_r;
    emit               = 1'b0;
    pair               = 1'b0;
    if (!halted_r) begin
      if (high_waiting_r) begin
        if (is_low) begin
          emit = 1'b1;
          pair = 1'b1;
        end else begin
          // broken pair: drop both units and go quiet
          halted_nxt = 1'b1;
        end
        high_waiting_nxt   = 1'b0;
        held_high_bits_nxt = '0;
      end else if (is_high) begin
        held_high_bits_nxt = unit[9:0];
        high_waiting_nxt   = 1'b1;
      end else if (!is_low) begin
        emit = 1'b1;
      end
    end
    if (end_of_string) begin
      held_high_bits_nxt = '0;
      high_waiting_nxt   = 1'b0;
      halted_nxt         = 1'b0;
    end
  end

  always_comb begin
    push_entry = '0;
    if (pair) begin
      push_entry.bytes[0] = u16u8_pkg::LEAD_4 | {5'b0, cp[20:18]};
      push_entry.bytes[1] = u16u8_pkg::CONT | {2'b0, cp[17:12]};
      push_entry.bytes[2] = u16u8_pkg::CONT | {2'b0, cp[11:6]};
      push_entry.bytes[3] = u16u8_pkg::CONT | {2'b0, cp[5:0]};
      push_entry.last_idx = 2'd3;
    end else if (unit < u16u8_pkg::ONE_BYTE_LIMIT) begin
      push_entry.bytes[0] = unit[7:0];
      push_entry.last_idx = 2'd0;
    end else if (unit < u16u8_pkg::TWO_BYTE_LIMIT) begin
      push_entry.bytes[0] = u16u8_pkg::LEAD_2 | {3'b0, unit[10:6]};
      push_entry.bytes[1] = u16u8_pkg::CONT | {2'b0, unit[5:0]};
      push_entry.last_idx = 2'd1;
    end else begin
      push_entry.bytes[0] = u16u8_pkg::LEAD_3 | {4'b0, unit[15:12]};
      push_entry.bytes[1] = u16u8_pkg::CONT | {2'b0, unit[11:6]};
      push_entry.bytes[2] = u16u8_pkg::CONT | {2'b0, unit[5:0]};
      push_entry.last_idx = 2'd2;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_high_bits_r <= '0;
      high_waiting_r   <= 1'b0;
      halted_r         <= 1'b0;
    end else if (accept) begin
      held_high_bits_r <= held_high_bits_nxt;
      high_waiting_r   <= high_waiting_nxt;
      halted_r         <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/u16u8_fifo.sv
`default_nettype none

module u16u8_fifo #(
  parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire u16u8_pkg::entry_t push_entry,
  input  wire logic              pop,
  output logic                   full,
  output logic                   head_valid,
  output u16u8_pkg::entry_t      head_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u16u8_pkg::entry_t entries_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

>>> hdl/u16u8_back.sv
`default_nettype none

module u16u8_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire u16u8_pkg::entry_t head_entry,
  output logic                   pop,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [7:0]             out_utf8_byte,
  output logic                   out_last_of_run
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       slot_free;
  logic       load;
  logic       at_last;

  assign slot_free = !out_valid_r || !out_stall;
  assign load      = head_valid && slot_free;
  assign at_last   = (idx_r == head_entry.last_idx);
  assign pop       = load && at_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (slot_free) begin
      out_valid_nxt = head_valid;
    end
    if (load) begin
      // advance through the entry, rewind once its final byte leaves
      idx_nxt = at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head_entry.bytes[idx_r];
      last_r <= at_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_utf8_byte   = byte_r;
  assign out_last_of_run = last_r;

endmodule

`default_nettype wire
